>>> design/cci_pkg.sv
// shared constants for the circle intersection block
// status codes and the default coordinate width; no dependencies
package cci_pkg;

	localparam int CCI_COORD_WIDTH = 32;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_ONE  = 2'd1;
	localparam logic [1:0] ST_TWO  = 2'd2;
	localparam logic [1:0] ST_COIN = 2'd3;

endpackage

>>> design/cci_sqrt_cell.sv
// one cell of the integer square root chain: one root bit per cycle while en is high
// standalone, instantiated in a row by circle_circle_intersection
module cci_sqrt_cell #(
	parameter int K  = 33,
	parameter int PW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*K-1:0]  in_rad,
	input  logic [K:0]      in_rem,
	input  logic [K-1:0]    in_root,
	input  logic [PW-1:0]   in_side,
	output logic            out_valid,
	output logic [2*K-1:0]  out_rad,
	output logic [K:0]      out_rem,
	output logic [K-1:0]    out_root,
	output logic [PW-1:0]   out_side
);

	logic [K+1:0] t;
	logic [K+1:0] trial;
	logic         ge;
	logic [K+1:0] diff;

	assign t     = {in_rem[K-1:0], in_rad[2*K-1:2*K-2]};
	assign trial = {in_root, 2'b01};
	assign ge    = t >= trial;
	assign diff  = ge ? t - trial : t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rad  <= {in_rad[2*K-3:0], 2'b00};
			out_rem  <= diff[K:0];
			out_root <= {in_root[K-2:0], ge};
			out_side <= in_side;
		end
	end

endmodule

>>> design/cci_div_cell.sv
// one cell of the restoring divider chain: one quotient bit per lane per cycle while en is high
// lanes share one divisor; standalone, used by circle_circle_intersection
module cci_div_cell #(
	parameter int DW    = 34,
	parameter int QW    = 34,
	parameter int LANES = 1,
	parameter int PW    = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [DW-1:0]              in_den,
	input  logic [LANES-1:0][DW-1:0]   in_rem,
	input  logic [LANES-1:0][QW-1:0]   in_nq,
	input  logic [PW-1:0]              in_side,
	output logic                       out_valid,
	output logic [DW-1:0]              out_den,
	output logic [LANES-1:0][DW-1:0]   out_rem,
	output logic [LANES-1:0][QW-1:0]   out_nq,
	output logic [PW-1:0]              out_side
);

	logic [LANES-1:0][DW:0]   t;
	logic [LANES-1:0]         ge;
	logic [LANES-1:0][DW:0]   diff;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			t[i]    = {in_rem[i], in_nq[i][QW-1]};
			ge[i]   = t[i] >= {1'b0, in_den};
			diff[i] = ge[i] ? t[i] - {1'b0, in_den} : t[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_den  <= in_den;
			out_side <= in_side;
			for (int i = 0; i < LANES; i++) begin
				out_rem[i] <= diff[i][DW-1:0];
				out_nq[i]  <= {in_nq[i][QW-2:0], ge[i]};
			end
		end
	end

endmodule

>>> design/circle_circle_intersection.sv
// intersection of two circles in signed fixed point
// depends on cci_pkg, cci_sqrt_cell and cci_div_cell
//
// usage
//   input channel in_valid / in_ready carries one item: two centres and two
//   radii. output channel out_valid / out_ready carries status and two points.
//   status: none, one point, two points, coincident; points are zero for
//   none and coincident, and equal for one point.
// timing
//   one item per cycle sustained while out_ready is high. the pipeline holds
//   three setup stages, a root chain of COORD_WIDTH+1 cells for the centre
//   distance, a divider chain of COORD_WIDTH+2 cells for tau, a product
//   stage, a root chain of COORD_WIDTH-1 cells for rho, a numerator stage, a
//   four lane divider chain of COORD_WIDTH+4 cells, then the output register.
// reset
//   arst_n clears all valid bits; the pipeline is empty after reset.
// stall
//   while a result waits with out_ready low the whole chain holds and
//   in_ready is low; it moves again the cycle out_ready returns.
module circle_circle_intersection
	import cci_pkg::*;
#(
	parameter int COORD_WIDTH = CCI_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] first_center_x,
	input  logic signed [COORD_WIDTH-1:0] first_center_y,
	input  logic        [COORD_WIDTH-2:0] first_radius,
	input  logic signed [COORD_WIDTH-1:0] second_center_x,
	input  logic signed [COORD_WIDTH-1:0] second_center_y,
	input  logic        [COORD_WIDTH-2:0] second_radius,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [1:0]             status,
	output logic signed [COORD_WIDTH-1:0] point_a_x,
	output logic signed [COORD_WIDTH-1:0] point_a_y,
	output logic signed [COORD_WIDTH-1:0] point_b_x,
	output logic signed [COORD_WIDTH-1:0] point_b_y
);

	localparam int C   = COORD_WIDTH;
	localparam int RW  = C - 1;
	localparam int MW  = C + 1;
	localparam int D2W = 2 * C + 2;
	localparam int LW  = C + 1;
	localparam int TW  = C + 2;
	localparam int RHW = C - 1;
	localparam int QS  = C + 4;
	localparam int NSW = 2 * C + 3;
	localparam int DSW = C + 1;
	localparam int EW  = QS + 3;

	typedef struct packed {
		logic [C-1:0]  x1;
		logic [C-1:0]  y1;
		logic [MW-1:0] adx;
		logic [MW-1:0] ady;
		logic          ndx;
		logic          ndy;
		logic          flip;
		logic [1:0]    st;
		logic          outer;
		logic          szero;
		logic [C-1:0]  s;
		logic [RW-1:0] r1;
		logic [RW-1:0] m;
	} sd_base_t;

	typedef struct packed {
		sd_base_t        b;
		logic [2*RW-1:0] r1sq;
		logic [2*RW-1:0] r2sq;
		logic [D2W-1:0]  num;
	} sd_a_t;

	typedef struct packed {
		sd_base_t        b;
		logic [2*RW-1:0] r1sq;
		logic [LW-1:0]   len;
		logic            tneg;
	} sd_b_t;

	typedef struct packed {
		sd_base_t       b;
		logic [LW-1:0]  len;
		logic           tneg;
		logic [NSW-1:0] px;
		logic [NSW-1:0] py;
	} sd_c_t;

	typedef struct packed {
		sd_base_t b;
		logic     tneg;
	} sd_d_t;

	localparam int PA = $bits(sd_a_t);
	localparam int PB = $bits(sd_b_t);
	localparam int PC = $bits(sd_c_t);
	localparam int PD = $bits(sd_d_t);

	function automatic logic [C-1:0] sat(input logic [EW-1:0] v);
		logic [EW-C:0] hi;
		hi = v[EW-1:C-1];
		if (hi == '0 || hi == '1) begin
			return v[C-1:0];
		end else if (v[EW-1]) begin
			return {1'b1, {(C-1){1'b0}}};
		end else begin
			return {1'b0, {(C-1){1'b1}}};
		end
	endfunction

	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 1: centre difference
	logic [C:0]    dx, dy;
	logic          v_s1;
	logic [C-1:0]  x1_s1, y1_s1;
	logic [RW-1:0] r1_s1, r2_s1;
	logic [MW-1:0] adx_s1, ady_s1;
	logic          ndx_s1, ndy_s1;

	assign dx = {second_center_x[C-1], second_center_x} - {first_center_x[C-1], first_center_x};
	assign dy = {second_center_y[C-1], second_center_y} - {first_center_y[C-1], first_center_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1  <= first_center_x;
			y1_s1  <= first_center_y;
			r1_s1  <= first_radius;
			r2_s1  <= second_radius;
			ndx_s1 <= dx[C];
			ndy_s1 <= dy[C];
			adx_s1 <= dx[C] ? ~dx + 1'b1 : dx;
			ady_s1 <= dy[C] ? ~dy + 1'b1 : dy;
		end
	end

	// stage 2: squares, radius sum and difference
	logic            v_s2;
	logic [C-1:0]    x1_s2, y1_s2, s_s2;
	logic [RW-1:0]   r1_s2, m_s2;
	logic [MW-1:0]   adx_s2, ady_s2;
	logic            ndx_s2, ndy_s2, flip_s2;
	logic [D2W-1:0]  sqx_s2, sqy_s2;
	logic [2*RW-1:0] r1sq_s2, r2sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s2   <= x1_s1;
			y1_s2   <= y1_s1;
			r1_s2   <= r1_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			ndx_s2  <= ndx_s1;
			ndy_s2  <= ndy_s1;
			flip_s2 <= !(r1_s1 > r2_s1);
			s_s2    <= {1'b0, r1_s1} + {1'b0, r2_s1};
			m_s2    <= (r1_s1 > r2_s1) ? r1_s1 - r2_s1 : r2_s1 - r1_s1;
			sqx_s2  <= adx_s1 * adx_s1;
			sqy_s2  <= ady_s1 * ady_s1;
			r1sq_s2 <= r1_s1 * r1_s1;
			r2sq_s2 <= r2_s1 * r2_s1;
		end
	end

	// stage 3: distance squared and squared radius bounds
	logic            v_s3;
	logic [C-1:0]    x1_s3, y1_s3, s_s3;
	logic [RW-1:0]   r1_s3, m_s3;
	logic [MW-1:0]   adx_s3, ady_s3;
	logic            ndx_s3, ndy_s3, flip_s3;
	logic [D2W-1:0]  d2_s3;
	logic [2*C-1:0]  s2sq_s3;
	logic [2*RW-1:0] m2sq_s3, r1sq_s3, r2sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s3   <= x1_s2;
			y1_s3   <= y1_s2;
			r1_s3   <= r1_s2;
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			ndx_s3  <= ndx_s2;
			ndy_s3  <= ndy_s2;
			flip_s3 <= flip_s2;
			s_s3    <= s_s2;
			m_s3    <= m_s2;
			r1sq_s3 <= r1sq_s2;
			r2sq_s3 <= r2sq_s2;
			d2_s3   <= sqx_s2 + sqy_s2;
			s2sq_s3 <= s_s2 * s_s2;
			m2sq_s3 <= m_s2 * m_s2;
		end
	end

	// classification
	logic  gt_s, lt_m, eq_s, eq_m, d_zero;
	sd_a_t sda;

	assign gt_s   = d2_s3 > {2'b0, s2sq_s3};
	assign lt_m   = d2_s3 < {4'b0, m2sq_s3};
	assign eq_s   = d2_s3 == {2'b0, s2sq_s3};
	assign eq_m   = d2_s3 == {4'b0, m2sq_s3};
	assign d_zero = d2_s3 == '0;

	always_comb begin
		sda.b.x1    = x1_s3;
		sda.b.y1    = y1_s3;
		sda.b.adx   = adx_s3;
		sda.b.ady   = ady_s3;
		sda.b.ndx   = ndx_s3;
		sda.b.ndy   = ndy_s3;
		sda.b.flip  = flip_s3;
		sda.b.outer = eq_s;
		sda.b.szero = s_s3 == '0;
		sda.b.s     = s_s3;
		sda.b.r1    = r1_s3;
		sda.b.m     = m_s3;
		sda.r1sq    = r1sq_s3;
		sda.r2sq    = r2sq_s3;
		sda.num     = {4'b0, r1sq_s3} + d2_s3;
		if (gt_s || lt_m) begin
			sda.b.st = ST_NONE;
		end else if (eq_s) begin
			sda.b.st = ST_ONE;
		end else if (d_zero) begin
			sda.b.st = ST_COIN;
		end else if (eq_m) begin
			sda.b.st = ST_ONE;
		end else begin
			sda.b.st = ST_TWO;
		end
	end

	// root chain for the centre distance
	logic [LW:0]    a_v;
	logic [D2W-1:0] a_rad  [0:LW];
	logic [LW:0]    a_rem  [0:LW];
	logic [LW-1:0]  a_root [0:LW];
	logic [PA-1:0]  a_sd   [0:LW];

	assign a_v[0]    = v_s3;
	assign a_rad[0]  = d2_s3;
	assign a_rem[0]  = '0;
	assign a_root[0] = '0;
	assign a_sd[0]   = sda;

	for (genvar i = 0; i < LW; i++) begin : g_root_len
		cci_sqrt_cell #(.K(LW), .PW(PA)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_valid(a_v[i]), .in_rad(a_rad[i]), .in_rem(a_rem[i]),
			.in_root(a_root[i]), .in_side(a_sd[i]),
			.out_valid(a_v[i+1]), .out_rad(a_rad[i+1]), .out_rem(a_rem[i+1]),
			.out_root(a_root[i+1]), .out_side(a_sd[i+1])
		);
	end

	// tau divider chain
	sd_a_t          sda_o;
	sd_b_t          sdb;
	logic           tneg;
	logic [D2W-1:0] nm;

	assign sda_o = sd_a_t'(a_sd[LW]);
	assign tneg  = sda_o.num < {4'b0, sda_o.r2sq};
	assign nm    = tneg ? {4'b0, sda_o.r2sq} - sda_o.num : sda_o.num - {4'b0, sda_o.r2sq};

	always_comb begin
		sdb.b    = sda_o.b;
		sdb.r1sq = sda_o.r1sq;
		sdb.len  = a_root[LW];
		sdb.tneg = tneg;
	end

	logic [TW:0]          b_v;
	logic [TW-1:0]        b_den [0:TW];
	logic [0:0][TW-1:0]   b_rem [0:TW];
	logic [0:0][TW-1:0]   b_nq  [0:TW];
	logic [PB-1:0]        b_sd  [0:TW];

	assign b_v[0]      = a_v[LW];
	assign b_den[0]    = {a_root[LW], 1'b0};
	assign b_rem[0][0] = {2'b0, nm[D2W-1:TW]};
	assign b_nq[0][0]  = nm[TW-1:0];
	assign b_sd[0]     = sdb;

	for (genvar i = 0; i < TW; i++) begin : g_div_tau
		cci_div_cell #(.DW(TW), .QW(TW), .LANES(1), .PW(PB)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_valid(b_v[i]), .in_den(b_den[i]), .in_rem(b_rem[i]),
			.in_nq(b_nq[i]), .in_side(b_sd[i]),
			.out_valid(b_v[i+1]), .out_den(b_den[i+1]), .out_rem(b_rem[i+1]),
			.out_nq(b_nq[i+1]), .out_side(b_sd[i+1])
		);
	end

	// stage 5: tau squared and tau products
	sd_b_t           sdb_o;
	logic [TW-1:0]   tm;
	logic            v_s5;
	sd_c_t           sdc_s5;
	logic [2*RW-1:0] r1sq_s5;
	logic [2*TW-1:0] t2_s5;

	assign sdb_o = sd_b_t'(b_sd[TW]);
	assign tm    = b_nq[TW][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= b_v[TW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sdc_s5.b    <= sdb_o.b;
			sdc_s5.len  <= sdb_o.len;
			sdc_s5.tneg <= sdb_o.tneg;
			sdc_s5.px   <= tm * sdb_o.b.adx;
			sdc_s5.py   <= tm * sdb_o.b.ady;
			r1sq_s5     <= sdb_o.r1sq;
			t2_s5       <= tm * tm;
		end
	end

	// root chain for rho
	logic [2*RHW-1:0] rd;
	assign rd = ({6'b0, r1sq_s5} > t2_s5) ? r1sq_s5 - t2_s5[2*RHW-1:0] : '0;

	logic [RHW:0]     c_v;
	logic [2*RHW-1:0] c_rad  [0:RHW];
	logic [RHW:0]     c_rem  [0:RHW];
	logic [RHW-1:0]   c_root [0:RHW];
	logic [PC-1:0]    c_sd   [0:RHW];

	assign c_v[0]    = v_s5;
	assign c_rad[0]  = rd;
	assign c_rem[0]  = '0;
	assign c_root[0] = '0;
	assign c_sd[0]   = sdc_s5;

	for (genvar i = 0; i < RHW; i++) begin : g_root_rho
		cci_sqrt_cell #(.K(RHW), .PW(PC)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_valid(c_v[i]), .in_rad(c_rad[i]), .in_rem(c_rem[i]),
			.in_root(c_root[i]), .in_side(c_sd[i]),
			.out_valid(c_v[i+1]), .out_rad(c_rad[i+1]), .out_rem(c_rem[i+1]),
			.out_root(c_root[i+1]), .out_side(c_sd[i+1])
		);
	end

	// stage 7: offset numerators and the shared divisor
	sd_c_t                 sdc_o;
	logic                  two;
	logic [RHW-1:0]        ma;
	logic                  v_s7;
	sd_d_t                 sdd_s7;
	logic [DSW-1:0]        den_s7;
	logic [3:0][NSW-1:0]   num_s7;
	logic [2*C-1:0]        p2, p3;

	assign sdc_o = sd_c_t'(c_sd[RHW]);
	assign two   = sdc_o.b.st == ST_TWO;
	assign ma    = two ? c_root[RHW] : sdc_o.b.r1;
	assign p2    = ma * sdc_o.b.adx;
	assign p3    = ma * sdc_o.b.ady;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= c_v[RHW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sdd_s7.b    <= sdc_o.b;
			sdd_s7.tneg <= sdc_o.tneg;
			num_s7[0]   <= two ? sdc_o.px : {3'b0, p2};
			num_s7[1]   <= two ? sdc_o.py : {3'b0, p3};
			num_s7[2]   <= {3'b0, p2};
			num_s7[3]   <= {3'b0, p3};
			if (two) begin
				den_s7 <= sdc_o.len;
			end else if (sdc_o.b.outer) begin
				den_s7 <= {1'b0, sdc_o.b.s};
			end else begin
				den_s7 <= {2'b0, sdc_o.b.m};
			end
		end
	end

	// four lane divider chain for the point offsets
	logic [QS:0]           d_v;
	logic [DSW-1:0]        d_den [0:QS];
	logic [3:0][DSW-1:0]   d_rem [0:QS];
	logic [3:0][QS-1:0]    d_nq  [0:QS];
	logic [PD-1:0]         d_sd  [0:QS];

	assign d_v[0]   = v_s7;
	assign d_den[0] = den_s7;
	assign d_sd[0]  = sdd_s7;

	for (genvar l = 0; l < 4; l++) begin : g_lane_init
		assign d_rem[0][l] = {2'b0, num_s7[l][NSW-1:QS]};
		assign d_nq[0][l]  = num_s7[l][QS-1:0];
	end

	for (genvar i = 0; i < QS; i++) begin : g_div_pts
		cci_div_cell #(.DW(DSW), .QW(QS), .LANES(4), .PW(PD)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_valid(d_v[i]), .in_den(d_den[i]), .in_rem(d_rem[i]),
			.in_nq(d_nq[i]), .in_side(d_sd[i]),
			.out_valid(d_v[i+1]), .out_den(d_den[i+1]), .out_rem(d_rem[i+1]),
			.out_nq(d_nq[i+1]), .out_side(d_sd[i+1])
		);
	end

	// point assembly and saturation
	sd_d_t              sdd_o;
	logic               two_o, use_a;
	logic [3:0]         neg;
	logic [3:0][EW-1:0] term;
	logic [EW-1:0]      xs, ys, ax, ay, bx, by;

	assign sdd_o = sd_d_t'(d_sd[QS]);
	assign two_o = sdd_o.b.st == ST_TWO;
	assign use_a = !(sdd_o.b.st == ST_ONE && sdd_o.b.szero);

	always_comb begin
		neg[0] = sdd_o.b.ndx ^ (two_o ? sdd_o.tneg : (!sdd_o.b.outer && sdd_o.b.flip));
		neg[1] = sdd_o.b.ndy ^ (two_o ? sdd_o.tneg : (!sdd_o.b.outer && sdd_o.b.flip));
		neg[2] = sdd_o.b.ndx;
		neg[3] = sdd_o.b.ndy;
		for (int l = 0; l < 4; l++) begin
			term[l] = neg[l] ? ~{3'b0, d_nq[QS][l]} + 1'b1 : {3'b0, d_nq[QS][l]};
		end
		if (!use_a) begin
			term[0] = '0;
			term[1] = '0;
		end
		if (!two_o) begin
			term[2] = '0;
			term[3] = '0;
		end
	end

	assign xs = {{(EW-C){sdd_o.b.x1[C-1]}}, sdd_o.b.x1};
	assign ys = {{(EW-C){sdd_o.b.y1[C-1]}}, sdd_o.b.y1};
	assign ax = xs + term[0] - term[3];
	assign ay = ys + term[1] + term[2];
	assign bx = xs + term[0] + term[3];
	assign by = ys + term[1] - term[2];

	logic [1:0]   status_q;
	logic [C-1:0] ax_q, ay_q, bx_q, by_q;
	logic         has_pts;

	assign has_pts = sdd_o.b.st == ST_ONE || sdd_o.b.st == ST_TWO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d_v[QS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= sdd_o.b.st;
			ax_q     <= has_pts ? sat(ax) : '0;
			ay_q     <= has_pts ? sat(ay) : '0;
			bx_q     <= has_pts ? sat(bx) : '0;
			by_q     <= has_pts ? sat(by) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign point_a_x = ax_q;
	assign point_a_y = ay_q;
	assign point_b_x = bx_q;
	assign point_b_y = by_q;

	a_no_points: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NONE || status == ST_COIN) |->
		point_a_x == '0 && point_a_y == '0 && point_b_x == '0 && point_b_y == '0)
		else $error("points not cleared for status without points");

	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ONE |->
		point_a_x == point_b_x && point_a_y == point_b_y)
		else $error("touching circles give two different points");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(d_v) && $stable(v_s7))
		else $error("pipeline moved while stalled");

endmodule
